FILE: rtl/icdf_pkg.sv
// icdf_pkg: shared types and constants for the inverse cdf sampler
// no dependencies
`timescale 1ns / 1ps
package icdf_pkg;
   localparam int unsigned CDF_W  = 33;
   localparam int unsigned FREQ_W = 54;
   localparam int unsigned RND_W  = 32;
   localparam int unsigned IDX_W  = 10;
   localparam int unsigned OPS_W  = 1;

   typedef enum logic [OPS_W-1:0] {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // request beat payload
   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   entry_index;
      logic [CDF_W-1:0]   cdf_value;
      logic [FREQ_W-1:0]  freq_value;
      logic [RND_W-1:0]   random_value;
   } req_type;

   // response beat payload
   typedef struct packed {
      logic [FREQ_W-1:0]  frequency;
      logic [IDX_W-1:0]   bin_index;
      logic               flat_bin;
   } rsp_type;
endpackage

FILE: rtl/icdf_if.sv
// icdf_req_if / icdf_rsp_if: valid/ready channels for the sampler
// depends on icdf_pkg
`timescale 1ns / 1ps
interface icdf_req_if
   import icdf_pkg::*;
();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface icdf_rsp_if
   import icdf_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/icdf_front.sv
// icdf_front: accepts request beats into a short queue
// depends on icdf_pkg
`timescale 1ns / 1ps
module icdf_front
   import icdf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    q_valid,
   input  logic    q_ready,
   output req_type q_data
);
   localparam int unsigned DEPTH = 2;
   req_type     mem_ff [DEPTH];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign in_ready = (cnt_ff != 2'(DEPTH));
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = mem_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   // pointer and count update
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end
endmodule

FILE: rtl/icdf_div.sv
// icdf_div: restoring divider, one quotient bit per cycle
// depends on icdf_pkg
`timescale 1ns / 1ps
module icdf_div
   import icdf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [86:0]       dividend,
   input  logic [CDF_W-1:0]  divisor,
   output logic              done,
   output logic [FREQ_W-1:0] quotient
);
   logic [86:0]      num_ff, num_in;
   logic [CDF_W:0]   rem_ff, rem_in;
   logic [CDF_W-1:0] d_ff, d_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [CDF_W+1:0] shifted, diff;

   assign shifted  = {rem_ff, num_ff[86]};
   assign diff     = shifted - {2'b00, d_ff};
   assign done     = busy_ff && (cnt_ff == 7'd0) ;
   assign quotient = num_ff[FREQ_W-1:0];

   // one dividend bit shifts into the remainder per cycle
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         d_in    = divisor;
         cnt_in  = 7'd87;
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff != 7'd0) begin
         if (!diff[CDF_W+1]) begin
            rem_in = diff[CDF_W:0];
            num_in = {num_ff[85:0], 1'b1};
         end else begin
            rem_in = shifted[CDF_W:0];
            num_in = {num_ff[85:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end
endmodule

FILE: rtl/icdf_back.sv
// icdf_back: table memory, binary search, interpolation and result register
// depends on icdf_pkg and icdf_div
`timescale 1ns / 1ps
module icdf_back
   import icdf_pkg::*;
#(
   parameter int unsigned NUM_BINS = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   output logic    q_ready,
   input  req_type q_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);
   localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int unsigned EW = CDF_W + FREQ_W;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_RD0   = 10'b0000000010,
      S_RDL   = 10'b0000000100,
      S_PROBE = 10'b0000001000,
      S_WAIT  = 10'b0000010000,
      S_RDA   = 10'b0000100000,
      S_RDB   = 10'b0001000000,
      S_MUL   = 10'b0010000000,
      S_MULH  = 10'b0100000000,
      S_DIV   = 10'b1000000000
   } state_type;

   logic [EW-1:0]     mem [NUM_BINS];
   logic [EW-1:0]     rd_ff;
   logic [AW-1:0]     raddr;
   state_type         st_ff, st_in;
   logic [AW:0]       lo_ff, lo_in, hi_ff, hi_in, mid, mid_nx;
   logic [RND_W-1:0]  x_ff, x_in;
   logic [CDF_W-1:0]  c0_ff, c0_in, c1;
   logic [FREQ_W-1:0] f0_ff, f0_in, f1, m_ff, m_in, fres;
   logic              up_ff, up_in, flat;
   logic [CDF_W-1:0]  w_ff, w_in, t_ff, t_in;
   logic [CDF_W:0]    wd;
   logic [CDF_W:0]    td;
   logic [86:0]       prod_ff, prod_in;
   logic [26:0]       m_sel;
   logic [59:0]       part;
   logic              ov_ff, ov_in, dstart, ddone;
   logic [FREQ_W-1:0] dq;
   rsp_type           res_ff, res_in;
   logic              load_ok;

   assign load_ok = (q_data.op == OP_LOAD) && (32'(q_data.entry_index) < NUM_BINS);
   assign q_ready = (st_ff == S_IDLE) && !ov_ff;
   assign out_valid = ov_ff;
   assign out_data  = res_ff;
   assign mid = (lo_ff + hi_ff) >> 1;
   assign mid_nx = (lo_in + hi_in) >> 1;
   assign c1  = rd_ff[EW-1:FREQ_W];
   assign f1  = rd_ff[FREQ_W-1:0];
   assign wd  = {1'b0, c1} - {1'b0, c0_ff};
   assign td  = {2'b00, x_ff} - {1'b0, c0_ff};
   assign dstart = (st_ff == S_MULH);

   // partial product, low half of the magnitude first, then the high half
   assign m_sel = (st_ff == S_MULH) ? m_ff[FREQ_W-1:27] : m_ff[26:0];
   assign part  = m_sel * t_ff;

   // read address per state
   always_comb begin
      unique case (st_ff)
         S_IDLE:  raddr = '0;
         S_RD0:   raddr = AW'(NUM_BINS - 1);
         S_RDL:   raddr = mid[AW-1:0];
         S_PROBE: raddr = mid_nx[AW-1:0];
         S_WAIT:  raddr = lo_ff[AW-1:0];
         S_RDA:   raddr = AW'(lo_ff + 1'b1);
         default: raddr = lo_ff[AW-1:0];
      endcase
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (q_valid && q_ready && load_ok) begin
         mem[q_data.entry_index[AW-1:0]] <= {q_data.cdf_value, q_data.freq_value};
      end
      rd_ff <= mem[raddr];
   end

   always_comb begin
      fres = up_ff ? f0_ff + dq : f0_ff - dq;
   end

   // search and interpolation sequencer
   always_comb begin
      st_in  = st_ff;
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      x_in   = x_ff;
      c0_in  = c0_ff;
      f0_in  = f0_ff;
      m_in   = m_ff;
      up_in  = up_ff;
      w_in   = w_ff;
      t_in   = t_ff;
      ov_in  = ov_ff;
      res_in = res_ff;
      prod_in = prod_ff;
      flat   = 1'b0;
      if (ov_ff && out_ready) ov_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (q_valid && q_ready && q_data.op == OP_SAMPLE) begin
               x_in  = q_data.random_value;
               st_in = S_RD0;
            end
         end
         S_RD0: begin
            // rd_ff holds entry 0
            lo_in = '0;
            hi_in = (AW+1)'(NUM_BINS - 1);
            if ({1'b0, x_ff} < rd_ff[EW-1:FREQ_W]) begin
               st_in = S_WAIT;
            end else begin
               st_in = S_RDL;
            end
         end
         S_RDL: begin
            // rd_ff holds last entry
            if ({1'b0, x_ff} >= rd_ff[EW-1:FREQ_W]) begin
               lo_in = (AW+1)'(NUM_BINS - 2);
               st_in = S_WAIT;
            end else if (hi_ff - lo_ff > 1) begin
               st_in = S_PROBE;
            end else begin
               st_in = S_WAIT;
            end
         end
         S_PROBE: begin
            // rd_ff holds entry mid; the next mid is read in the same cycle
            if ({1'b0, x_ff} >= rd_ff[EW-1:FREQ_W]) lo_in = mid;
            else hi_in = mid;
            if ({1'b0, x_ff} >= rd_ff[EW-1:FREQ_W]) begin
               if (hi_ff - mid <= 1) st_in = S_WAIT;
            end else if (mid - lo_ff <= 1) begin
               st_in = S_WAIT;
            end
         end
         S_WAIT: st_in = S_RDA;
         S_RDA: begin
            c0_in = rd_ff[EW-1:FREQ_W];
            f0_in = rd_ff[FREQ_W-1:0];
            st_in = S_RDB;
         end
         S_RDB: begin
            flat = wd[CDF_W] || (wd == '0);
            w_in = wd[CDF_W-1:0];
            up_in = (f1 >= f0_ff);
            m_in = (f1 >= f0_ff) ? f1 - f0_ff : f0_ff - f1;
            if (td[CDF_W]) t_in = '0;
            else if (td > wd) t_in = wd[CDF_W-1:0];
            else t_in = td[CDF_W-1:0];
            if (flat) begin
               res_in = '{frequency: f0_ff, bin_index: IDX_W'(lo_ff), flat_bin: 1'b1};
               ov_in  = 1'b1;
               st_in  = S_IDLE;
            end else begin
               st_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = 87'(part);
            st_in   = S_MULH;
         end
         S_MULH: begin
            // the divider takes the finished product in this cycle
            prod_in = prod_ff + {part, 27'b0};
            st_in   = S_DIV;
         end
         S_DIV: begin
            if (ddone) begin
               res_in = '{frequency: fres, bin_index: IDX_W'(lo_ff), flat_bin: 1'b0};
               ov_in  = 1'b1;
               st_in  = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   // product accumulator ahead of the divider
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   icdf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dstart),
      .dividend (prod_in),
      .divisor  (w_ff),
      .done     (ddone),
      .quotient (dq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      x_ff   <= x_in;
      c0_ff  <= c0_in;
      f0_ff  <= f0_in;
      m_ff   <= m_in;
      up_ff  <= up_in;
      w_ff   <= w_in;
      t_ff   <= t_in;
      res_ff <= res_in;
   end
endmodule

FILE: rtl/inverse_cdf_sampler_unit.sv
// channel  dir  payload
// req      in   op, entry_index, cdf_value, freq_value, random_value
// rsp      out  frequency, bin_index, flat_bin
// a load in range writes its table entry as the back end takes it; a sample runs through the
// bisection memory reads, the two-step multiply and the 87-step serial divider
// synchronous active-high reset clears control only; table is undefined until written
// a two-beat queue lets loads and samples queue while the back end works or rsp stalls
// depends on icdf_pkg, icdf_if, icdf_front, icdf_back
`timescale 1ns / 1ps
module inverse_cdf_sampler_unit
   import icdf_pkg::*;
#(
   parameter int unsigned NUM_BINS = 1024
) (
   input logic        clock,
   input logic        reset,
   icdf_req_if.sink   req,
   icdf_rsp_if.source rsp
);
   logic    q_valid, q_ready;
   req_type q_data;

   icdf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .in_data  (req.payload),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_data   (q_data)
   );

   icdf_back #(.NUM_BINS(NUM_BINS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp.payload)
   );

   // a pending result blocks the back end from taking more work
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid)
      else $error("result dropped while stalled");
   a_noq: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !q_ready)
      else $error("back end took work with result pending");
endmodule
